@@ src/sli_pkg.sv @@
// Shared types and constants for the sorted list intersection block.
// No dependencies; used by sli_cell, sli_chain and sorted_list_intersection.
package sli_pkg;

    // Element width of both lists
    localparam int unsigned VALUE_W = 32;
    // Number of result cells, which also caps the number of results
    localparam int unsigned RESULT_CAP = 64;
    // Default capacity of each list store
    localparam int unsigned MAX_LEN_DEF = 64;

    // One value moving along the cell chain, or held in a cell
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } t_link;

endpackage

@@ src/sli_cell.sv @@
// One cell of the sorting chain: holds one distinct value, passes larger ones on.
// Depends on sli_pkg.
module sli_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  sli_pkg::t_link i_in,
    input  sli_pkg::t_link i_next,
    output sli_pkg::t_link o_pass,
    output sli_pkg::t_link o_held
);

    sli_pkg::t_link r_held;
    sli_pkg::t_link r_pass;

    // Insert: keep the smaller, hand the larger on, drop a duplicate.
    // Shift: take the neighbor's value so the chain drains toward the head.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_pass <= '0;
        end else if (i_shift) begin
            r_held <= i_next;
            r_pass <= '0;
        end else begin
            r_pass <= '0;
            if (i_in.valid) begin
                if (!r_held.valid) begin
                    r_held <= i_in;
                end else if (i_in.value == r_held.value) begin
                    r_pass <= '0;
                end else if (i_in.value < r_held.value) begin
                    r_held <= i_in;
                    r_pass <= r_held;
                end else begin
                    r_pass <= i_in;
                end
            end
        end
    end

    assign o_pass = r_pass;
    assign o_held = r_held;

endmodule

@@ src/sli_chain.sv @@
// Row of sorting cells that keeps the smallest distinct values in ascending order.
// Depends on sli_pkg and sli_cell.
module sli_chain #(
    parameter int unsigned DEPTH = sli_pkg::RESULT_CAP
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  sli_pkg::t_link i_insert,
    output sli_pkg::t_link o_head,
    output sli_pkg::t_link o_second,
    output sli_pkg::t_link o_spill
);

    // w_fwd[k] feeds cell k on the insert path; w_held[k] is cell k's value
    sli_pkg::t_link w_fwd  [0:DEPTH];
    sli_pkg::t_link w_held [0:DEPTH];

    assign w_fwd[0]      = i_insert;
    assign w_held[DEPTH] = '0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        sli_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_in    (w_fwd[k]),
            .i_next  (w_held[k+1]),
            .o_pass  (w_fwd[k+1]),
            .o_held  (w_held[k])
        );
    end

    assign o_head   = w_held[0];
    assign o_second = w_held[1];
    // Value pushed past the last cell (larger than everything kept)
    assign o_spill  = w_fwd[DEPTH];

endmodule

@@ src/sorted_list_intersection.sv @@
// Sorted list intersection: top level with list stores, pair scan and control.
// Depends on sli_pkg and sli_chain.
//
// Usage: elements of both lists are loaded one per cycle (a transaction is
// accepted when start is high and busy is low); which_list picks the list and
// end_of_list closes it. Each list holds MAX_LEN elements, extra ones are
// dropped and reported through o_overflowed. Once both lists are closed, busy
// rises and the block compares every first-list entry against every
// second-list entry, one pair per cycle out of the two list stores; the
// sorting chain is then left to settle before the first result is registered.
// Results then come out one per cycle in ascending order, each distinct common
// value once, the final one flagged by o_last_result; an empty intersection
// gives one result with o_empty_result.
// The receiver cannot stall: every o_result_valid pulse must be taken. Busy
// drops in the cycle the final result is presented.
module sorted_list_intersection #(
    parameter int unsigned MAX_LEN = sli_pkg::MAX_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_which_list,
    input  logic [sli_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_end_of_list,
    output logic                        o_result_valid,
    output logic [sli_pkg::VALUE_W-1:0] o_common_value,
    output logic                        o_last_result,
    output logic                        o_empty_result,
    output logic                        o_overflowed
);

    localparam int unsigned IW = $clog2(MAX_LEN);
    localparam int unsigned CW = $clog2(MAX_LEN + 1);
    localparam int unsigned SW = $clog2(sli_pkg::RESULT_CAP + 3);

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_SETTLE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_first_count, n_first_count;
    logic [CW-1:0] r_second_count, n_second_count;
    logic          r_first_done, n_first_done;
    logic          r_second_done, n_second_done;
    logic          r_overflow, n_overflow;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_j, n_j;
    logic [SW-1:0] r_wait, n_wait;
    logic          r_rd_valid, n_rd_valid;

    logic                        r_out_valid, n_out_valid;
    logic [sli_pkg::VALUE_W-1:0] r_out_value, n_out_value;
    logic                        r_out_last, n_out_last;
    logic                        r_out_empty, n_out_empty;
    logic                        r_out_ovf, n_out_ovf;

    logic [sli_pkg::VALUE_W-1:0] r_first_mem  [0:MAX_LEN-1];
    logic [sli_pkg::VALUE_W-1:0] r_second_mem [0:MAX_LEN-1];
    logic [sli_pkg::VALUE_W-1:0] r_a;
    logic [sli_pkg::VALUE_W-1:0] r_b;

    logic           w_accept;
    logic           w_wr_first;
    logic           w_wr_second;
    logic           w_shift;
    logic           w_i_last;
    logic           w_j_last;
    sli_pkg::t_link w_insert;
    sli_pkg::t_link w_head;
    sli_pkg::t_link w_second;
    sli_pkg::t_link w_spill;

    assign busy     = (r_state != ST_LOAD);
    assign w_accept = start && !busy;

    // Store writes for elements that fit
    assign w_wr_first  = w_accept && !i_which_list && !r_first_done &&
                         (r_first_count != CW'(MAX_LEN));
    assign w_wr_second = w_accept && i_which_list && !r_second_done &&
                         (r_second_count != CW'(MAX_LEN));

    assign w_i_last = (CW'(r_i) + CW'(1)) == r_first_count;
    assign w_j_last = (CW'(r_j) + CW'(1)) == r_second_count;

    // List stores: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (w_wr_first) begin
            r_first_mem[r_first_count[IW-1:0]] <= i_value;
        end
        r_a <= r_first_mem[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_second) begin
            r_second_mem[r_second_count[IW-1:0]] <= i_value;
        end
        r_b <= r_second_mem[r_j];
    end

    // A matching pair goes into the sorting chain
    assign w_insert.valid = r_rd_valid && (r_a == r_b);
    assign w_insert.value = r_a;

    assign w_shift = (r_state == ST_EMIT) && w_head.valid;

    sli_chain #(
        .DEPTH (sli_pkg::RESULT_CAP)
    ) u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_shift),
        .i_insert (w_insert),
        .o_head   (w_head),
        .o_second (w_second),
        .o_spill  (w_spill)
    );

    // Control: load, pair scan, chain settle, result drain
    always_comb begin
        n_state        = r_state;
        n_first_count  = r_first_count;
        n_second_count = r_second_count;
        n_first_done   = r_first_done;
        n_second_done  = r_second_done;
        n_overflow     = r_overflow;
        n_i            = r_i;
        n_j            = r_j;
        n_wait         = r_wait;
        n_rd_valid     = 1'b0;
        n_out_valid    = 1'b0;
        n_out_value    = r_out_value;
        n_out_last     = r_out_last;
        n_out_empty    = r_out_empty;
        n_out_ovf      = r_out_ovf;

        case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (!i_which_list && !r_first_done) begin
                        if (w_wr_first) begin
                            n_first_count = r_first_count + CW'(1);
                        end else begin
                            n_overflow = 1'b1;
                        end
                        n_first_done = i_end_of_list;
                    end
                    if (i_which_list && !r_second_done) begin
                        if (w_wr_second) begin
                            n_second_count = r_second_count + CW'(1);
                        end else begin
                            n_overflow = 1'b1;
                        end
                        n_second_done = i_end_of_list;
                    end
                    if (n_first_done && n_second_done) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                n_rd_valid = (r_first_count != '0) && (r_second_count != '0);
                if (w_j_last || (r_second_count == '0)) begin
                    n_j = '0;
                    if (w_i_last || (r_first_count == '0)) begin
                        n_wait  = SW'(sli_pkg::RESULT_CAP + 2);
                        n_state = ST_SETTLE;
                    end else begin
                        n_i = r_i + IW'(1);
                    end
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            ST_SETTLE: begin
                if (r_wait == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    n_wait = r_wait - SW'(1);
                end
            end
            ST_EMIT: begin
                n_out_valid = 1'b1;
                n_out_ovf   = r_overflow;
                if (!w_head.valid) begin
                    n_out_value = '0;
                    n_out_last  = 1'b1;
                    n_out_empty = 1'b1;
                end else begin
                    n_out_value = w_head.value;
                    n_out_last  = !w_second.valid;
                    n_out_empty = 1'b0;
                end
                if (n_out_last) begin
                    n_first_count  = '0;
                    n_second_count = '0;
                    n_first_done   = 1'b0;
                    n_second_done  = 1'b0;
                    n_overflow     = 1'b0;
                    n_state        = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_LOAD;
            r_first_count  <= '0;
            r_second_count <= '0;
            r_first_done   <= 1'b0;
            r_second_done  <= 1'b0;
            r_overflow     <= 1'b0;
            r_i            <= '0;
            r_j            <= '0;
            r_wait         <= '0;
            r_rd_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_first_count  <= n_first_count;
            r_second_count <= n_second_count;
            r_first_done   <= n_first_done;
            r_second_done  <= n_second_done;
            r_overflow     <= n_overflow;
            r_i            <= n_i;
            r_j            <= n_j;
            r_wait         <= n_wait;
            r_rd_valid     <= n_rd_valid;
            r_out_valid    <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_result_valid = r_out_valid;
    assign o_common_value = r_out_value;
    assign o_last_result  = r_out_last;
    assign o_empty_result = r_out_empty;
    assign o_overflowed   = r_out_ovf;

    // Results only come out of the drain state
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state) == ST_EMIT)
        else $error("result strobe outside drain");

    // An empty intersection is always a single, final result
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_empty_result |-> o_last_result)
        else $error("empty result not marked last");

    // Results of one transaction rise strictly and come back to back
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last_result |=>
            o_result_valid && (o_common_value > $past(o_common_value)))
        else $error("results not strictly ascending");

    // The chain can only spill when lists may exceed the result cap
    a_no_spill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_spill.valid |-> (MAX_LEN > sli_pkg::RESULT_CAP))
        else $error("sorting chain spilled a value");

endmodule
